@@ sv/two_point_thermal_calibration_defines.svh @@
// ----------------------------------------------------------------------------
// two_point_thermal_calibration_defines
// Assertion macros for the thermal calibration block.
// ----------------------------------------------------------------------------
`ifndef TWO_POINT_THERMAL_CALIBRATION_DEFINES_SVH
`define TWO_POINT_THERMAL_CALIBRATION_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TPTC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TPTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tptc_pkg.sv @@
// ----------------------------------------------------------------------------
// tptc_pkg
// Widths, constants and the coefficient bundle of the thermal calibration.
// ----------------------------------------------------------------------------
`default_nettype none

package tptc_pkg;

	localparam int RAW_W     = 12;
	localparam int CALIB_W   = 32;
	localparam int CNT_W     = 12;
	localparam int THOT_W    = 8;
	localparam int HOT_LSB   = 20;
	localparam int ROOM_LSB  = 8;
	localparam int DT_W      = 10;
	localparam int DEN_W     = 13;
	localparam int DTMAG_W   = 8;
	localparam int MAG1_W    = 18;
	localparam int PROD_W    = 20;
	localparam int MAG2_W    = 30;
	localparam int DIV_STEPS = 30;
	localparam int SLOPE_W   = 19;
	localparam int OUT_W     = 32;
	localparam int MUL_W     = 32;
	localparam int SUM_W     = 34;
	localparam int MILLI     = 1000;

	typedef struct packed {
		logic                      err;
		logic signed [SLOPE_W-1:0] slope;
		logic signed [OUT_W-1:0]   offset;
	} coef_t;

endpackage

`default_nettype wire

@@ sv/two_point_thermal_calibration.sv @@
// ----------------------------------------------------------------------------
// two_point_thermal_calibration
// Raw 12-bit sensor count to millidegrees Celsius via two-point calibration.
// ----------------------------------------------------------------------------
// Usage:
//   Config: calib_we writes calib_word (hot count 31:20, room count 19:8,
//   hot temperature 7:0). After each write busy is high while the slope and
//   offset divisions run, one quotient bit per cycle; when the two counts
//   are equal there is nothing to divide and busy is high for a single cycle.
//   Input: a transaction is taken at a clock edge with start high and busy
//   low; raw_count is sampled there; one is taken per cycle while not busy.
//   Output: done is high for one cycle with temp_millicelsius and
//   calib_error, after the stage 1, multiply, add and saturate registers.
//   Results leave in order, one per transaction.
//   The receiver cannot stall; results are never held back.
//   Equal hot and room counts give calib_error high and a zero result.
//   Reset: calib_word clears to zero, so results carry calib_error until
//   a valid word is written; pipeline valids clear, busy is low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_point_thermal_calibration_defines.svh"

module two_point_thermal_calibration #(
	parameter int ROOM_TEMP_C = 25
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                calib_we,
	input  wire logic [tptc_pkg::CALIB_W-1:0]        calib_word,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [tptc_pkg::RAW_W-1:0]          raw_count,
	output logic                                     done,
	output logic signed [tptc_pkg::OUT_W-1:0]        temp_millicelsius,
	output logic                                     calib_error
);

	tptc_pkg::coef_t                       coef;
	logic                                  accept;

	logic                                  valid_s1;
	logic [tptc_pkg::RAW_W-1:0]            raw_s1;
	tptc_pkg::coef_t                       coef_s1;

	logic                                  valid_s2;
	logic signed [tptc_pkg::MUL_W-1:0]     prod_s2;
	logic signed [tptc_pkg::OUT_W-1:0]     offset_s2;
	logic                                  err_s2;

	logic                                  valid_s3;
	logic signed [tptc_pkg::SUM_W-1:0]     sum_s3;
	logic                                  err_s3;

	logic                                  done_q;
	logic signed [tptc_pkg::OUT_W-1:0]     temp_q;
	logic                                  err_q;

	logic signed [tptc_pkg::MUL_W-1:0]     raw_x;
	logic signed [tptc_pkg::MUL_W-1:0]     slope_x;
	logic signed [tptc_pkg::MUL_W-1:0]     prod;
	logic signed [tptc_pkg::SUM_W-1:0]     sum;
	logic signed [tptc_pkg::OUT_W-1:0]     sat;

	tptc_coef #(
		.ROOM_TEMP_C (ROOM_TEMP_C)
	) u_coef (
		.clk        (clk),
		.arst_n     (arst_n),
		.calib_we   (calib_we),
		.calib_word (calib_word),
		.coef       (coef),
		.busy       (busy)
	);

	assign accept = start && !busy;

	assign raw_x   = {{(tptc_pkg::MUL_W - tptc_pkg::RAW_W){1'b0}}, raw_s1};
	assign slope_x = {{(tptc_pkg::MUL_W - tptc_pkg::SLOPE_W){coef_s1.slope[tptc_pkg::SLOPE_W-1]}},
		coef_s1.slope};
	assign prod    = raw_x * slope_x;

	assign sum = {{(tptc_pkg::SUM_W - tptc_pkg::MUL_W){prod_s2[tptc_pkg::MUL_W-1]}}, prod_s2}
		+ {{(tptc_pkg::SUM_W - tptc_pkg::OUT_W){offset_s2[tptc_pkg::OUT_W-1]}}, offset_s2};

	always_comb begin
		if (!sum_s3[tptc_pkg::SUM_W-1]
			&& sum_s3[tptc_pkg::SUM_W-2:tptc_pkg::OUT_W-1] != '0) begin
			sat = {1'b0, {(tptc_pkg::OUT_W-1){1'b1}}};
		end else if (sum_s3[tptc_pkg::SUM_W-1]
			&& sum_s3[tptc_pkg::SUM_W-2:tptc_pkg::OUT_W-1] != '1) begin
			sat = {1'b1, {(tptc_pkg::OUT_W-1){1'b0}}};
		end else begin
			sat = sum_s3[tptc_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1  <= raw_count;
			coef_s1 <= coef;
		end
		prod_s2   <= prod;
		offset_s2 <= coef_s1.offset;
		err_s2    <= coef_s1.err;
		sum_s3    <= sum;
		err_s3    <= err_s2;
		temp_q    <= err_s3 ? '0 : sat;
		err_q     <= err_s3;
	end

	assign done              = done_q;
	assign temp_millicelsius = temp_q;
	assign calib_error       = err_q;

	`TPTC_ASSERT_NEXT(a_accept_enters, start && !busy, valid_s1, "accepted transaction lost")
	`TPTC_ASSERT_NEXT(a_s3_gives_done, valid_s3, done, "result strobe missing")
	`TPTC_ASSERT_NEXT(a_no_stray_done, !valid_s3, !done, "result strobe without transaction")
	`TPTC_ASSERT_SAME(a_err_zero, done && calib_error, temp_millicelsius == '0, "error result not zero")
	`TPTC_ASSERT_NEXT(a_write_busy, calib_we, busy, "busy not raised after calibration write")

endmodule

`default_nettype wire

@@ sv/tptc_coef.sv @@
// ----------------------------------------------------------------------------
// tptc_coef
// Holds the fuse word and derives slope and offset from it with two parallel
// one-bit-per-cycle restoring dividers, run after each write with unequal counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tptc_coef #(
	parameter int ROOM_TEMP_C = 25
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           calib_we,
	input  wire logic [tptc_pkg::CALIB_W-1:0]   calib_word,
	output tptc_pkg::coef_t                     coef,
	output logic                                busy
);

	localparam int STEP_W = $clog2(tptc_pkg::DIV_STEPS);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_SCALE = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_FIN   = 5'b10000
	} coef_state_t;

	typedef struct packed {
		logic [tptc_pkg::CNT_W-1:0]  rem;
		logic [tptc_pkg::MAG2_W-1:0] num;
	} div_t;

	function automatic div_t div_step(div_t cur, logic [tptc_pkg::CNT_W-1:0] dv);
		logic [tptc_pkg::CNT_W:0]   sh;
		logic [tptc_pkg::CNT_W+1:0] trial;
		div_t                       nxt;
		sh    = {cur.rem, cur.num[tptc_pkg::MAG2_W-1]};
		trial = {1'b0, sh} - {2'b00, dv};
		if (!trial[tptc_pkg::CNT_W+1]) begin
			nxt.rem = trial[tptc_pkg::CNT_W-1:0];
			nxt.num = {cur.num[tptc_pkg::MAG2_W-2:0], 1'b1};
		end else begin
			nxt.rem = sh[tptc_pkg::CNT_W-1:0];
			nxt.num = {cur.num[tptc_pkg::MAG2_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	coef_state_t                        state_q;
	logic [tptc_pkg::CALIB_W-1:0]       calib_q;
	logic [STEP_W-1:0]                  step_q;
	logic [tptc_pkg::CNT_W-1:0]         den_mag_q;
	logic                               sign1_q;
	logic                               sign2_q;
	logic [tptc_pkg::MAG1_W-1:0]        mag1_q;
	logic [tptc_pkg::PROD_W-1:0]        prod_q;
	div_t                               div1_q;
	div_t                               div2_q;
	logic                               err_q;
	logic signed [tptc_pkg::SLOPE_W-1:0] slope_q;
	logic signed [tptc_pkg::OUT_W-1:0]  offset_q;

	logic [tptc_pkg::CNT_W-1:0]         n_hot;
	logic [tptc_pkg::CNT_W-1:0]         n_room;
	logic [tptc_pkg::THOT_W-1:0]        t_hot;
	logic signed [tptc_pkg::DT_W-1:0]   dt;
	logic signed [tptc_pkg::DEN_W-1:0]  den;
	logic [tptc_pkg::DTMAG_W-1:0]       dt_mag;
	logic [tptc_pkg::CNT_W-1:0]         den_mag;
	logic [tptc_pkg::SLOPE_W-1:0]       q1_x;
	logic [tptc_pkg::OUT_W-1:0]         q2_x;
	logic [tptc_pkg::OUT_W-1:0]         q2_s;
	logic [tptc_pkg::OUT_W-1:0]         base;

	assign n_hot   = calib_q[tptc_pkg::HOT_LSB +: tptc_pkg::CNT_W];
	assign n_room  = calib_q[tptc_pkg::ROOM_LSB +: tptc_pkg::CNT_W];
	assign t_hot   = calib_q[tptc_pkg::THOT_W-1:0];
	assign dt      = {2'b00, t_hot} - tptc_pkg::DT_W'(ROOM_TEMP_C);
	assign den     = {1'b0, n_hot} - {1'b0, n_room};
	assign dt_mag  = dt[tptc_pkg::DT_W-1] ? tptc_pkg::DTMAG_W'(-dt) : dt[tptc_pkg::DTMAG_W-1:0];
	assign den_mag = den[tptc_pkg::DEN_W-1] ? tptc_pkg::CNT_W'(-den) : den[tptc_pkg::CNT_W-1:0];

	assign q1_x = {1'b0, div1_q.num[tptc_pkg::MAG1_W-1:0]};
	assign q2_x = {2'b00, div2_q.num};
	assign q2_s = sign2_q ? -q2_x : q2_x;
	assign base = tptc_pkg::OUT_W'(t_hot * tptc_pkg::MILLI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			calib_q <= '0;
			err_q   <= 1'b1;
			step_q  <= '0;
		end else if (calib_we) begin
			state_q <= ST_MUL;
			calib_q <= calib_word;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				ST_MUL: begin
					if (den == '0) begin
						err_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(tptc_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					err_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			den_mag_q <= den_mag;
			sign1_q   <= (!dt[tptc_pkg::DT_W-1] && dt != '0) ^ den[tptc_pkg::DEN_W-1];
			sign2_q   <= dt[tptc_pkg::DT_W-1] ^ den[tptc_pkg::DEN_W-1];
			mag1_q    <= tptc_pkg::MAG1_W'(dt_mag * tptc_pkg::MILLI);
			prod_q    <= tptc_pkg::PROD_W'(n_room) * tptc_pkg::PROD_W'(dt_mag);
		end
		if (state_q == ST_SCALE) begin
			div1_q.rem <= '0;
			div1_q.num <= {{(tptc_pkg::MAG2_W - tptc_pkg::MAG1_W){1'b0}}, mag1_q};
			div2_q.rem <= '0;
			div2_q.num <= tptc_pkg::MAG2_W'(prod_q * tptc_pkg::MILLI);
		end
		if (state_q == ST_DIV) begin
			div1_q <= div_step(div1_q, den_mag_q);
			div2_q <= div_step(div2_q, den_mag_q);
		end
		if (state_q == ST_FIN) begin
			slope_q  <= sign1_q ? -q1_x : q1_x;
			offset_q <= base + q2_s;
		end
	end

	assign coef.err    = err_q;
	assign coef.slope  = slope_q;
	assign coef.offset = offset_q;
	assign busy        = (state_q != ST_IDLE);

endmodule

`default_nettype wire
